// ===== hdl/tked_pkg.sv =====
// Shared key codes, byte constants and decode result type for the key escape decoder.
`timescale 1ns / 1ps

package tked_pkg;

  typedef enum logic [3:0] {
    KEY_PLAIN      = 4'd0,
    KEY_RUBOUT     = 4'd1,
    KEY_PGUP       = 4'd2,
    KEY_PGDN       = 4'd3,
    KEY_ESC        = 4'd4,
    KEY_LINE_BEGIN = 4'd5,
    KEY_DEL        = 4'd6,
    KEY_END        = 4'd7,
    KEY_UP         = 4'd8,
    KEY_ARROW_DN   = 4'd9,
    KEY_ARROW_RT   = 4'd10,
    KEY_ARROW_LT   = 4'd11
  } key_t;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_TIMEOUT = 1'b1;

  localparam logic [7:0] CH_CTRL_B   = 8'd2;
  localparam logic [7:0] CH_CTRL_F   = 8'd6;
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_O        = 8'h4F;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_F        = 8'h46;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_1        = 8'h31;
  localparam logic [7:0] CH_3        = 8'h33;
  localparam logic [7:0] CH_4        = 8'h34;
  localparam logic [7:0] CH_5        = 8'h35;
  localparam logic [7:0] CH_6        = 8'h36;
  localparam logic [7:0] CH_7        = 8'h37;
  localparam logic [7:0] CH_8        = 8'h38;
  localparam logic [7:0] CH_9        = 8'h39;

  typedef struct packed {
    logic       emit;
    key_t       key;
    logic [7:0] ch;
  } tked_res_t;

endpackage

// ===== hdl/tked_in_stage.sv =====
// Input register stage: holds one received transaction until the decoder consumes it.
`timescale 1ns / 1ps

module tked_in_stage import tked_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_byte_in,
  input  logic       advance,
  output logic       s1_valid,
  output logic       s1_mode,
  output logic [7:0] s1_byte
);

  logic       valid_r;
  logic       mode_r;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || advance;
  assign s1_valid = valid_r;
  assign s1_mode  = mode_r;
  assign s1_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      byte_r <= in_byte_in;
    end
  end

endmodule

// ===== hdl/tked_decode.sv =====
// Escape sequence state machine and per-byte key decision.
`timescale 1ns / 1ps

module tked_decode import tked_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic       mode,
  input  logic [7:0] byte_in,
  output tked_res_t  res
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_ONE   = 2'd2,
    PH_DIGIT = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic       is_digit;

  assign is_digit = (byte_in >= CH_0) && (byte_in <= CH_9);

  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    res.emit   = 1'b0;
    res.key    = KEY_ESC;
    res.ch     = 8'd0;
    unique case (phase_r)
      PH_IDLE: begin
        if (mode == MODE_BYTE) begin
          res.emit = 1'b1;
          case (byte_in)
            CH_DEL, CH_BS: res.key = KEY_RUBOUT;
            CH_CTRL_B:     res.key = KEY_PGUP;
            CH_CTRL_F:     res.key = KEY_PGDN;
            CH_ESC: begin
              res.emit  = 1'b0;
              phase_nxt = PH_ESC;
            end
            default: begin
              res.key = KEY_PLAIN;
              res.ch  = byte_in;
            end
          endcase
        end
      end
      PH_ESC: begin
        if (mode == MODE_TIMEOUT) begin
          res.emit  = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          first_nxt = byte_in;
          phase_nxt = PH_ONE;
        end
      end
      PH_ONE: begin
        res.emit  = 1'b1;
        phase_nxt = PH_IDLE;
        if (mode == MODE_BYTE) begin
          second_nxt = byte_in;
          if (first_r == CH_LBRACKET) begin
            if (is_digit) begin
              res.emit  = 1'b0;
              phase_nxt = PH_DIGIT;
            end else begin
              case (byte_in)
                CH_A:    res.key = KEY_UP;
                CH_B:    res.key = KEY_ARROW_DN;
                CH_C:    res.key = KEY_ARROW_RT;
                CH_D:    res.key = KEY_ARROW_LT;
                CH_H:    res.key = KEY_LINE_BEGIN;
                CH_F:    res.key = KEY_END;
                default: res.key = KEY_ESC;
              endcase
            end
          end else if (first_r == CH_O) begin
            if (byte_in == CH_H) begin
              res.key = KEY_LINE_BEGIN;
            end else if (byte_in == CH_F) begin
              res.key = KEY_END;
            end
          end
        end
      end
      PH_DIGIT: begin
        res.emit  = 1'b1;
        phase_nxt = PH_IDLE;
        if (mode == MODE_BYTE && byte_in == CH_TILDE) begin
          case (second_r)
            CH_1, CH_7: res.key = KEY_LINE_BEGIN;
            CH_3:       res.key = KEY_DEL;
            CH_4, CH_8: res.key = KEY_END;
            CH_5:       res.key = KEY_PGUP;
            CH_6:       res.key = KEY_PGDN;
            default:    res.key = KEY_ESC;
          endcase
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      first_r  <= 8'd0;
      second_r <= 8'd0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== hdl/terminal_key_escape_decoder.sv =====
// Top level: keyboard byte / timeout stream in, decoded key transactions out.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   input    | in_valid / in_ready    | in_mode[0:0], in_byte_in[7:0]
//   result   | out_valid / out_ready  | out_key_code[3:0], out_char_value[7:0]
//
// One transaction per cycle sustained while the result side keeps up; a result
// passes through the input register, then the result register, and can be
// accepted from the result register while out_valid is high.
// The decode step between the two registers is a single small lookup.
// Reset clears both valid flags and returns the sequence tracker to idle.
// A stalled result holds in the output register; the input register still
// drains transactions that produce no result, and refills as the result leaves.
`timescale 1ns / 1ps

module terminal_key_escape_decoder import tked_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_key_code,
  output logic [7:0] out_char_value
);

  logic       s1_valid;
  logic       s1_mode;
  logic [7:0] s1_byte;
  logic       advance;
  logic       out_free;
  tked_res_t  res;

  logic       out_valid_r;
  logic [3:0] out_key_r;
  logic [7:0] out_char_r;

  assign out_free = !out_valid_r || out_ready;
  // Advance the held transaction unless its result has nowhere to go.
  assign advance  = s1_valid && (!res.emit || out_free);

  tked_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_byte_in (in_byte_in),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1_mode    (s1_mode),
    .s1_byte    (s1_byte)
  );

  tked_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .mode    (s1_mode),
    .byte_in (s1_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_key_r  <= 4'(res.key);
      out_char_r <= res.ch;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_code   = out_key_r;
  assign out_char_value = out_char_r;

  a_char_only_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_key_code != 4'(KEY_PLAIN)) |-> (out_char_value == 8'd0))
    else $error("non-plain key carries a character");

  a_key_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_code <= 4'(KEY_ARROW_LT)))
    else $error("key code out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !(advance && res.emit))
    else $error("result register overwritten while stalled");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_byte) && $stable(s1_mode)))
    else $error("held input transaction lost or changed");

endmodule

// ===== dv/tb.sv =====
// Testbench for the terminal key escape decoder: directed and random byte streams, scoreboarded.
`timescale 1ns / 1ps

module tb;
  import tked_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_ESC   = 2'd1,
    SEQ_LEAD  = 2'd2,
    SEQ_DIGIT = 2'd3
  } seq_phase_t;

  typedef struct {
    key_t       key;
    logic [7:0] ch;
  } key_event_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic       in_mode    = MODE_BYTE;
  logic [7:0] in_byte_in = 8'd0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [3:0] out_key_code;
  logic [7:0] out_char_value;

  // decoder shadow state
  seq_phase_t seq_phase  = SEQ_IDLE;
  logic [7:0] lead_byte  = 8'd0;
  logic [7:0] digit_byte = 8'd0;
  key_event_t expected_keys[$];

  logic [7:0] bracket_finals[6] = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
  logic [7:0] control_bytes[5]  = '{CH_CTRL_B, CH_CTRL_F, CH_BS, CH_ESC, CH_DEL};

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int key_items     = 0;
  int err_count     = 0;
  int stall_cycles  = 0;

  terminal_key_escape_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_byte_in     (in_byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_code   (out_key_code),
    .out_char_value (out_char_value)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // Advance the shadow decoder by one accepted transaction.
  task automatic decode_key(input logic mode, input logic [7:0] b);
    key_event_t ev;
    logic       hit;
    hit    = 1'b0;
    ev.key = KEY_ESC;
    ev.ch  = 8'd0;
    if (seq_phase == SEQ_IDLE) begin
      if (mode == MODE_BYTE) begin
        hit = 1'b1;
        case (b)
          CH_DEL, CH_BS: ev.key = KEY_RUBOUT;
          CH_CTRL_B:     ev.key = KEY_PGUP;
          CH_CTRL_F:     ev.key = KEY_PGDN;
          CH_ESC: begin
            hit       = 1'b0;
            seq_phase = SEQ_ESC;
          end
          default: begin
            ev.key = KEY_PLAIN;
            ev.ch  = b;
          end
        endcase
      end
    end else if (mode == MODE_TIMEOUT) begin
      hit       = 1'b1;
      seq_phase = SEQ_IDLE;
    end else begin
      case (seq_phase)
        SEQ_ESC: begin
          lead_byte = b;
          seq_phase = SEQ_LEAD;
        end
        SEQ_LEAD: begin
          digit_byte = b;
          seq_phase  = SEQ_IDLE;
          hit        = 1'b1;
          if (lead_byte == CH_LBRACKET && b >= CH_0 && b <= CH_9) begin
            hit       = 1'b0;
            seq_phase = SEQ_DIGIT;
          end else if (lead_byte == CH_LBRACKET) begin
            case (b)
              CH_A:    ev.key = KEY_UP;
              CH_B:    ev.key = KEY_ARROW_DN;
              CH_C:    ev.key = KEY_ARROW_RT;
              CH_D:    ev.key = KEY_ARROW_LT;
              CH_H:    ev.key = KEY_LINE_BEGIN;
              CH_F:    ev.key = KEY_END;
              default: ev.key = KEY_ESC;
            endcase
          end else if (lead_byte == CH_O) begin
            if (b == CH_H) ev.key = KEY_LINE_BEGIN;
            else if (b == CH_F) ev.key = KEY_END;
          end
        end
        default: begin
          hit       = 1'b1;
          seq_phase = SEQ_IDLE;
          if (b == CH_TILDE) begin
            case (digit_byte)
              CH_1, CH_7: ev.key = KEY_LINE_BEGIN;
              CH_3:       ev.key = KEY_DEL;
              CH_4, CH_8: ev.key = KEY_END;
              CH_5:       ev.key = KEY_PGUP;
              CH_6:       ev.key = KEY_PGDN;
              default:    ev.key = KEY_ESC;
            endcase
          end
        end
      endcase
    end
    if (hit) expected_keys.push_back(ev);
  endtask

  task automatic send_key(input logic mode, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_byte_in <= b;
    do @(posedge clk); while (!in_ready);
    // a timeout while idle is swallowed and does not count as traffic
    if (!(seq_phase == SEQ_IDLE && mode == MODE_TIMEOUT)) key_items++;
    decode_key(mode, b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_key(MODE_BYTE, b);
  endtask

  task automatic send_timeout();
    send_key(MODE_TIMEOUT, 8'($urandom_range(255)));
  endtask

  // Hold the input side until every pending key has come out.
  task automatic drain_keys();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_keys();
    send_byte(CH_DEL);
    send_byte(CH_BS);
    send_byte(CH_CTRL_B);
    send_byte(CH_CTRL_F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_timeout();
  endtask

  task automatic test_escape_sequences();
    send_byte(CH_ESC); send_byte(CH_LBRACKET); send_byte(CH_A);
    send_byte(CH_ESC); send_byte(CH_O); send_byte(CH_H);
    send_byte(CH_ESC); send_byte(CH_LBRACKET); send_byte(CH_3); send_byte(CH_TILDE);
    send_byte(CH_ESC); send_byte(CH_LBRACKET); send_byte(CH_9); send_byte(CH_TILDE);
    send_byte(CH_ESC); send_byte(CH_O); send_byte(CH_A);
  endtask

  task automatic test_sequence_timeouts();
    send_byte(CH_ESC); send_timeout();
    send_byte(CH_ESC); send_byte(CH_LBRACKET); send_byte(CH_6); send_timeout();
  endtask

  task automatic send_escape_sequence();
    logic [7:0] seq[$];
    logic       cut;
    seq = '{CH_ESC};
    cut = 1'b0;
    case ($urandom_range(5))
      0: begin
        seq.push_back(CH_LBRACKET);
        seq.push_back(bracket_finals[$urandom_range(5)]);
      end
      1: begin
        seq.push_back(CH_O);
        seq.push_back($urandom_range(1) ? CH_H : CH_F);
      end
      2: begin
        seq.push_back(CH_LBRACKET);
        seq.push_back(8'($urandom_range(CH_0, CH_9)));
        seq.push_back(CH_TILDE);
      end
      3: begin
        seq.push_back(CH_LBRACKET);
        seq.push_back(8'($urandom_range(CH_0, CH_9)));
        seq.push_back(8'($urandom_range(255)));
      end
      4: begin
        seq.push_back($urandom_range(1) ? CH_LBRACKET : CH_O);
        seq.push_back(8'($urandom_range(255)));
      end
      default: begin
        seq.push_back(8'($urandom_range(255)));
        seq.push_back(8'($urandom_range(255)));
      end
    endcase
    for (int i = 0; i < seq.size() && !cut; i++) begin
      // drop the rest of the sequence behind a timeout now and then
      if (i > 0 && $urandom_range(99) < 6) begin
        send_timeout();
        cut = 1'b1;
      end else begin
        send_byte(seq[i]);
      end
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(9))
      0:       send_timeout();
      1:       send_byte(control_bytes[$urandom_range(4)]);
      default: send_byte(8'($urandom_range(255)));
    endcase
  endtask

  task automatic test_random_traffic(input int n);
    int start;
    start = key_items;
    while (key_items - start < n) begin
      if ($urandom_range(99) < 65) send_escape_sequence();
      else send_noise();
    end
  endtask

  // scoreboard
  always @(posedge clk) begin
    key_event_t ev;
    if (rst_n && out_valid && out_ready) begin
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected key %0d char %0d",
                                  out_key_code, out_char_value));
      end else begin
        ev = expected_keys.pop_front();
        if (out_key_code !== ev.key)
          report_mismatch($sformatf("key_code %0d, want %0d", out_key_code, ev.key));
        if (out_char_value !== ev.ch)
          report_mismatch($sformatf("char_value %0d, want %0d", out_char_value, ev.ch));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL terminal_key_escape_decoder");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 63;
    test_idle_keys();
    test_escape_sequences();
    test_sequence_timeouts();
    drain_keys();
    test_random_traffic(260);
    drain_keys();

    send_idle_pct = 63;
    recv_idle_pct = 28;
    test_random_traffic(260);
    drain_keys();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(260);
    drain_keys();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_keys.size() == 0) begin
      $display("PASS terminal_key_escape_decoder");
    end else begin
      $display("FAIL terminal_key_escape_decoder");
    end
    $finish;
  end

endmodule
